/* rtl/stpd_pkg.sv */
// shared types, constants and the sine table for the sliding tone power detector
package stpd_pkg;

    // default parameter values
    localparam int MAX_WINDOW_DEF   = 128;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // fixed datapath widths
    localparam int PHASE_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int WLEN_W      = 8;
    localparam int SUM_W       = 40;
    localparam int SUM_SHIFT   = 7;
    localparam int MUL_W       = SUM_W - SUM_SHIFT;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int HALF_W      = 32;
    localparam int ENTRY_W     = 2 * HALF_W;
    localparam int POWER_W     = 64;
    localparam int TRIG_W      = 17;

    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 8'd25;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP = 1'b0,
        CFG_WINDOW_LEN = 1'b1
    } cfg_index_t;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_COS   = 2'd0,
        MUL_NSIN  = 2'd1,
        MUL_SQ_RE = 2'd2,
        MUL_SQ_IM = 2'd3
    } mul_sel_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_MIX_RE = 3'd1,
        ST_MIX_IM = 3'd2,
        ST_UPDATE = 3'd3,
        ST_SQ_RE  = 3'd4,
        ST_SQ_IM  = 3'd5,
        ST_DONE   = 3'd6
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        mul_sel_t mul_sel;
        logic     cap_re;
        logic     update;
        logic     cap_sq;
        logic     load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic out_busy;
    } dp_status_t;

    typedef logic [0:64][15:0] quarter_rom_t;

    // quarter wave of sin in Q1.15 from the integer cosine recurrence
    function automatic quarter_rom_t build_quarter_rom();
        quarter_rom_t rom;
        longint prev;
        longint cur;
        longint nxt;
        longint val;
        prev   = 0;
        cur    = 64'sd26350943;
        rom[0] = 16'd0;
        rom[1] = 16'((cur + 64'sd16384) >>> 15);
        for (int k = 1; k < 64; k++) begin
            nxt  = ((64'sd2146836866 * cur + (64'sd1 <<< 29)) >>> 30) - prev;
            prev = cur;
            cur  = nxt;
            val  = (nxt < 0) ? 64'sd0 : nxt;
            val  = (val + 64'sd16384) >>> 15;
            if (val > 64'sd32767) begin
                val = 64'sd32767;
            end
            rom[k+1] = 16'(val);
        end
        return rom;
    endfunction

    localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

    // full-cycle sine lookup, 256 points, mirrored and negated quadrants
    function automatic logic signed [TRIG_W-1:0] rom_sin(input logic [7:0] addr);
        logic [5:0]               k;
        logic [6:0]               mk;
        logic [15:0]              v;
        logic signed [TRIG_W-1:0] sv;
        k  = addr[5:0];
        mk = 7'd64 - {1'b0, k};
        v  = addr[6] ? QUARTER_ROM[mk] : QUARTER_ROM[k];
        sv = $signed({1'b0, v});
        return addr[7] ? -sv : sv;
    endfunction

endpackage

/* rtl/sliding_tone_power_detector.sv */
// top level of the sliding single-bin tone power detector
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      s_sample, s_restart
//  m_       out        m_valid / m_ready      m_power
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a sample runs from transfer to the next s_ready through cos mix, sin mix
// and sum update while the window fills, and also through two squares once
// it yields a power: the controller walks one shared 33x33 multiplier.
// reset is synchronous and active low; the product ring needs no clearing.
// the finished power waits in an output register, and only the next result
// stalls on a held m_ready; configuration is always taken.
module sliding_tone_power_detector #(
    parameter int MAX_WINDOW   = stpd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = stpd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     s_sample,
    input  logic                               s_restart,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [stpd_pkg::POWER_W-1:0]       m_power,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import stpd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    stpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath
    stpd_datapath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_sample  (s_sample),
        .s_restart (s_restart),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_power   (m_power)
    );

endmodule

/* rtl/stpd_ctrl.sv */
// sequencing state machine of the sliding tone power detector
module stpd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output stpd_pkg::dp_cmd_t    cmd,
    input  stpd_pkg::dp_status_t status
);
    import stpd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MIX_RE;
                end
            end
            ST_MIX_RE: state_next = ST_MIX_IM;
            ST_MIX_IM: state_next = ST_UPDATE;
            ST_UPDATE: state_next = status.emit ? ST_SQ_RE : ST_IDLE;
            ST_SQ_RE:  state_next = ST_SQ_IM;
            ST_SQ_IM:  state_next = ST_DONE;
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = MUL_COS;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_MIX_RE: cmd.mul_sel = MUL_COS;
            ST_MIX_IM: begin
                cmd.mul_sel = MUL_NSIN;
                cmd.cap_re  = 1'b1;
            end
            ST_UPDATE: cmd.update = 1'b1;
            ST_SQ_RE:  cmd.mul_sel = MUL_SQ_RE;
            ST_SQ_IM: begin
                cmd.mul_sel = MUL_SQ_IM;
                cmd.cap_sq  = 1'b1;
            end
            ST_DONE: begin
                cmd.mul_sel  = MUL_SQ_IM;
                cmd.load_out = !status.out_busy;
            end
            default: s_ready = 1'b0;
        endcase
    end

endmodule

/* rtl/stpd_datapath.sv */
// mixer, product ring, running sums and power datapath
module stpd_datapath #(
    parameter int MAX_WINDOW   = stpd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = stpd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  stpd_pkg::dp_cmd_t                  cmd,
    output stpd_pkg::dp_status_t               status,
    input  logic signed [SAMPLE_WIDTH-1:0]     s_sample,
    input  logic                               s_restart,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [stpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               m_ready,
    output logic                               m_valid,
    output logic [stpd_pkg::POWER_W-1:0]       m_power
);
    import stpd_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);

    // configuration
    logic [PHASE_W-1:0] phase_step_reg;
    logic [WLEN_W-1:0]  window_len_reg;

    // block state
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [WLEN_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [SUM_W-1:0]      sum_re_reg, sum_re_next;
    logic [SUM_W-1:0]      sum_im_reg, sum_im_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [PROD_W-1:0]       mul_reg, mul_next;
    logic [SUM_W-1:0]               pr_reg;
    logic [POWER_W-1:0]             acc_reg;
    logic [POWER_W-1:0]             power_reg;
    logic [ENTRY_W-1:0]             rd_reg;
    logic [ENTRY_W-1:0]             ring [0:MAX_WINDOW-1];

    // combinational helpers
    logic [WLEN_W-1:0]        eff_len;
    logic                     filling;
    logic [PTR_W-1:0]         wptr;
    logic [PTR_W-1:0]         wptr_inc;
    logic [7:0]               trig_addr;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] nsin_val;
    logic signed [MUL_W-1:0]  samp_ext;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [SUM_W-1:0]         pi_val;
    logic [SUM_W-1:0]         old_re, old_im;

    // effective window length: zero acts as one, capped at the ring depth
    always_comb begin
        if (window_len_reg == '0) begin
            eff_len = WLEN_W'(1);
        end else if (32'(window_len_reg) > 32'(MAX_WINDOW)) begin
            eff_len = WLEN_W'(MAX_WINDOW);
        end else begin
            eff_len = window_len_reg;
        end
    end

    // ring slot for this sample and the next pointer
    always_comb begin
        filling = fill_reg < eff_len;
        if (!filling && (16'(ptr_reg) >= 16'(eff_len))) begin
            wptr = '0;
        end else begin
            wptr = ptr_reg;
        end
        if (16'(wptr) + 16'd1 == 16'(eff_len)) begin
            wptr_inc = '0;
        end else begin
            wptr_inc = wptr + PTR_W'(1);
        end
    end

    assign status.emit     = !filling || (9'(fill_reg) + 9'd1 == 9'(eff_len));
    assign status.out_busy = out_valid_reg && !m_ready;

    // mixer operands and the shared multiplier
    always_comb begin
        trig_addr = phase_reg[PHASE_W-1 -: 8];
        cos_val   = rom_sin(trig_addr + 8'd64);
        nsin_val  = -rom_sin(trig_addr);
        samp_ext  = MUL_W'(sample_reg);
        case (cmd.mul_sel)
            MUL_COS: begin
                mul_a = samp_ext;
                mul_b = MUL_W'(cos_val);
            end
            MUL_NSIN: begin
                mul_a = samp_ext;
                mul_b = MUL_W'(nsin_val);
            end
            MUL_SQ_RE: begin
                mul_a = $signed(sum_re_reg[SUM_W-1:SUM_SHIFT]);
                mul_b = $signed(sum_re_reg[SUM_W-1:SUM_SHIFT]);
            end
            default: begin
                mul_a = $signed(sum_im_reg[SUM_W-1:SUM_SHIFT]);
                mul_b = $signed(sum_im_reg[SUM_W-1:SUM_SHIFT]);
            end
        endcase
        mul_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // running sums: add newest product, drop the replaced one once full
    always_comb begin
        pi_val = mul_reg[SUM_W-1:0];
        old_re = filling ? '0 : SUM_W'($signed(rd_reg[ENTRY_W-1:HALF_W]));
        old_im = filling ? '0 : SUM_W'($signed(rd_reg[HALF_W-1:0]));
    end

    // next values of the block state
    always_comb begin
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        sum_re_next = sum_re_reg;
        sum_im_next = sum_im_reg;
        if (cmd.accept && s_restart) begin
            phase_next  = '0;
            fill_next   = '0;
            ptr_next    = '0;
            sum_re_next = '0;
            sum_im_next = '0;
        end else if (cmd.update) begin
            phase_next  = phase_reg + phase_step_reg;
            fill_next   = filling ? fill_reg + WLEN_W'(1) : fill_reg;
            ptr_next    = wptr_inc;
            sum_re_next = sum_re_reg + pr_reg - old_re;
            sum_im_next = sum_im_reg + pi_val - old_im;
        end
    end

    // output register next valid
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            window_len_reg <= WINDOW_LEN_RESET;
            phase_reg      <= '0;
            fill_reg       <= '0;
            ptr_reg        <= '0;
            sum_re_reg     <= '0;
            sum_im_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            sum_re_reg    <= sum_re_next;
            sum_im_reg    <= sum_im_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_PHASE_STEP: phase_step_reg <= cfg_data;
                    CFG_WINDOW_LEN: window_len_reg <= cfg_data[WLEN_W-1:0];
                    default:        phase_step_reg <= phase_step_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mul_reg <= mul_next;
        if (cmd.accept) begin
            sample_reg <= s_sample;
        end
        if (cmd.cap_re) begin
            pr_reg <= mul_reg[SUM_W-1:0];
        end
        if (cmd.cap_sq) begin
            acc_reg <= mul_reg[POWER_W-1:0];
        end
        if (cmd.load_out) begin
            power_reg <= acc_reg + mul_reg[POWER_W-1:0];
        end
    end

    // product ring: one write on each sum update and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            ring[wptr] <= {pr_reg[HALF_W-1:0], pi_val[HALF_W-1:0]};
        end
        rd_reg <= ring[wptr];
    end

    assign m_valid = out_valid_reg;
    assign m_power = power_reg;

endmodule
